// File: src/padded_radix_number_formatter_unit_macros.svh
// Assertion helpers for the formatter checks.
`ifndef PADDED_RADIX_NUMBER_FORMATTER_UNIT_MACROS_SVH
`define PADDED_RADIX_NUMBER_FORMATTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PRNF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("prnf check failed");

// Next-cycle implication, disabled while reset is held.
`define PRNF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("prnf check failed");

`endif

// File: src/prnf_pkg.sv
`timescale 1ns / 1ps
package prnf_pkg;

  localparam int VALUE_W = 32;
  localparam int WIDTH_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic MODE_HEX = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h61;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               mode;
    logic               fill_zero;
    logic [WIDTH_W-1:0] width;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic norm;
    logic pad_load;
    logic pad_dec;
    logic emit_fill;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic norm_stop;
    logic pad_zero;
    logic digit_last;
  } ctrl_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= 4'd9) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: src/padded_radix_number_formatter_unit.sv
`timescale 1ns / 1ps
// Padded radix number formatter.
// Request: pulse start with in_req (value, mode, fill_zero, width) while busy
// is low; the request is taken at that clock edge and busy rises next cycle.
// Results: one ASCII character per out_strobe cycle in out_rsp, most
// significant first: fill characters up to the (saturated) width, then the
// digits; out_rsp.last marks the final character. Results cannot be held off.
// Timing: decimal conversion shifts the value through a double-dabble
// register, one bit per cycle; hex loads directly.
// Leading zero digits are then stripped one per cycle, and characters leave
// one per cycle. busy falls in the cycle that shows the last character,
// and a new request may be taken in that same cycle.
// Reset clears the controller and the result strobe; no request survives.
module padded_radix_number_formatter_unit
  import prnf_pkg::*;
#(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 10,
  parameter int MAX_WIDTH   = 63
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_strobe,
  output rsp_t out_rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  prnf_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .mode (in_req.mode),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  prnf_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .DIGIT_SLOTS(DIGIT_SLOTS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

endmodule

// File: src/prnf_ctrl.sv
`timescale 1ns / 1ps
module prnf_ctrl
  import prnf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      mode,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (mode == MODE_DEC) ? ST_CONV : ST_NORM;
        end
      end
      ST_CONV: begin
        if (sts.conv_last) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_stop) state_nxt = ST_PAD;
      end
      ST_PAD: begin
        if (sts.pad_zero) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.digit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: cmd.conv = 1'b1;
      ST_NORM: begin
        cmd.norm     = !sts.norm_stop;
        cmd.pad_load = sts.norm_stop;
      end
      ST_PAD: begin
        cmd.pad_dec   = !sts.pad_zero;
        cmd.emit_fill = !sts.pad_zero;
      end
      ST_EMIT: cmd.emit_digit = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

// File: src/prnf_datapath.sv
`timescale 1ns / 1ps
module prnf_datapath
  import prnf_pkg::*;
#(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 10,
  parameter int MAX_WIDTH   = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      in_req,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output logic      out_strobe,
  output rsp_t      out_rsp
);

  localparam int DW    = 4 * DIGIT_SLOTS;
  localparam int EXT_W = (VALUE_BITS > DW) ? VALUE_BITS : DW;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int ND_W  = $clog2(DIGIT_SLOTS + 1);

  logic [EXT_W-1:0]      ext;
  logic [DW-1:0]         adj;
  logic [3:0]            top_dig;
  logic [WIDTH_W-1:0]    wsat;

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [DW-1:0]         dig_r, dig_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ND_W-1:0]       nd_r, nd_nxt;
  logic [WIDTH_W-1:0]    wid_r, wid_nxt;
  logic [WIDTH_W-1:0]    pad_r, pad_nxt;
  logic [CHAR_W-1:0]     fill_r, fill_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  rsp_t                  out_rsp_r, out_rsp_nxt;

  // value masked to VALUE_BITS and zero-extended
  for (genvar i = 0; i < EXT_W; i++) begin : g_ext
    if (i < VALUE_BITS && i < VALUE_W) begin : g_bit
      assign ext[i] = in_req.value[i];
    end else begin : g_zero
      assign ext[i] = 1'b0;
    end
  end

  // double-dabble add-3 adjust
  always_comb begin
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      adj[4*k +: 4] = (dig_r[4*k +: 4] >= 4'd5) ? dig_r[4*k +: 4] + 4'd3 : dig_r[4*k +: 4];
    end
  end

  assign top_dig = dig_r[DW-1 -: 4];
  assign wsat    = (in_req.width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : in_req.width;

  always_comb begin
    bin_nxt        = bin_r;
    dig_nxt        = dig_r;
    ovf_nxt        = ovf_r;
    cnt_nxt        = cnt_r;
    nd_nxt         = nd_r;
    wid_nxt        = wid_r;
    pad_nxt        = pad_r;
    fill_nxt       = fill_r;
    out_strobe_nxt = cmd.emit_fill | cmd.emit_digit;
    out_rsp_nxt.character = cmd.emit_fill ? fill_r : digit_char(top_dig);
    out_rsp_nxt.last      = cmd.emit_digit && (nd_r == ND_W'(1));

    if (cmd.load) begin
      bin_nxt  = ext[VALUE_BITS-1:0];
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      nd_nxt   = ND_W'(DIGIT_SLOTS);
      wid_nxt  = wsat;
      fill_nxt = in_req.fill_zero ? ASCII_ZERO : ASCII_SPACE;
      if (in_req.mode == MODE_DEC) begin
        dig_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        dig_nxt = ext[DW-1:0];
        ovf_nxt = |(ext >> DW);
      end
    end

    if (cmd.conv) begin
      bin_nxt = bin_r << 1;
      dig_nxt = {adj[DW-2:0], bin_r[VALUE_BITS-1]};
      ovf_nxt = ovf_r | adj[DW-1];
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (cmd.norm || cmd.emit_digit) begin
      dig_nxt = dig_r << 4;
      nd_nxt  = nd_r - ND_W'(1);
    end

    if (cmd.pad_load) begin
      pad_nxt = (wid_r > WIDTH_W'(nd_r)) ? wid_r - WIDTH_W'(nd_r) : '0;
    end

    if (cmd.pad_dec) begin
      pad_nxt = pad_r - WIDTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    dig_r     <= dig_nxt;
    ovf_r     <= ovf_nxt;
    cnt_r     <= cnt_nxt;
    nd_r      <= nd_nxt;
    wid_r     <= wid_nxt;
    pad_r     <= pad_nxt;
    fill_r    <= fill_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign sts.conv_last  = (cnt_r == '0);
  assign sts.norm_stop  = ovf_r || (nd_r == ND_W'(1)) || (top_dig != 4'd0);
  assign sts.pad_zero   = (pad_r == '0);
  assign sts.digit_last = (nd_r == ND_W'(1));

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

// File: src/prnf_checker.sv
`timescale 1ns / 1ps
`include "padded_radix_number_formatter_unit_macros.svh"
module prnf_checker
  import prnf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input rsp_t out_rsp
);

  `PRNF_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PRNF_ASSERT_NOW(a_strobe_in_req, clk, rst_n, out_strobe, $past(busy))
  `PRNF_ASSERT_NOW(a_last_ends, clk, rst_n, out_strobe && out_rsp.last, !busy)
  `PRNF_ASSERT_NOW(a_end_marked, clk, rst_n, $fell(busy), out_strobe && out_rsp.last)

endmodule

bind padded_radix_number_formatter_unit prnf_checker u_prnf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_rsp   (out_rsp)
);
